>>> hw/rtl/opp_pkg.sv
// ----------------------------------------------------------------------------
// opp_pkg
// Shared constants and types of the onset peak picker: parameter defaults,
// configuration register map and the control group of the window statistics.
// ----------------------------------------------------------------------------
package opp_pkg;

    localparam int HALF_WINDOW_DEF = 10;
    localparam int FLUX_BITS_DEF   = 24;
    localparam int INDEX_BITS_DEF  = 20;

    // threshold scale register
    localparam int SCALE_BITS = 4;
    localparam int KK_BITS    = 2 * SCALE_BITS;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 4'd6;

    // register map: one 32-bit register, word index taken from paddr[2]
    localparam int APB_DATA_BITS = 32;
    localparam int ADDR_BITS     = 3;
    localparam logic REG_THRESHOLD_SCALE = 1'b0;

    // control of the window sum / square sum / count unit
    typedef struct packed {
        logic clear;
        logic square;
        logic accum;
        logic add;
        logic sub;
    } win_ctrl_t;

    // status of the threshold test pipeline
    typedef struct packed {
        logic done;
        logic hit;
    } test_res_t;

endpackage

>>> hw/rtl/opp_cell.sv
// ----------------------------------------------------------------------------
// opp_cell
// One cell of the flux history line: holds one frame value and takes its
// neighbor's value on a shift, or zero on a clear.
// ----------------------------------------------------------------------------
module opp_cell #(
    parameter int FLUX_BITS = opp_pkg::FLUX_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 clear,
    input  logic [FLUX_BITS-1:0] din,
    output logic [FLUX_BITS-1:0] dout
);

    logic [FLUX_BITS-1:0] value_reg;
    logic [FLUX_BITS-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (clear)
        begin
            value_next = '0;
        end
        else if (shift)
        begin
            value_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign dout = value_reg;

endmodule

>>> hw/rtl/opp_window.sv
// ----------------------------------------------------------------------------
// opp_window
// Running statistics of the sliding window: frame count, sum and sum of
// squares. Squares are formed in one step and accumulated in the next.
// ----------------------------------------------------------------------------
module opp_window #(
    parameter int FLUX_BITS   = opp_pkg::FLUX_BITS_DEF,
    parameter int HALF_WINDOW = opp_pkg::HALF_WINDOW_DEF,
    localparam int NB = $clog2(2 * HALF_WINDOW + 2),
    localparam int SB = FLUX_BITS + NB,
    localparam int QB = 2 * FLUX_BITS + NB
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  opp_pkg::win_ctrl_t      ctrl,
    input  logic [FLUX_BITS-1:0]    add_val,
    input  logic [FLUX_BITS-1:0]    sub_val,
    output logic [NB-1:0]           count,
    output logic [SB-1:0]           sum,
    output logic [QB-1:0]           sqsum
);
    import opp_pkg::*;

    localparam int PW = 2 * FLUX_BITS;

    logic [PW-1:0] add_sq_reg;
    logic [PW-1:0] sub_sq_reg;
    logic [NB-1:0] count_reg;
    logic [NB-1:0] count_next;
    logic [SB-1:0] sum_reg;
    logic [SB-1:0] sum_next;
    logic [QB-1:0] sqsum_reg;
    logic [QB-1:0] sqsum_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.square)
        begin
            add_sq_reg <= PW'(add_val) * PW'(add_val);
            sub_sq_reg <= PW'(sub_val) * PW'(sub_val);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sqsum_next = sqsum_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
            sum_next   = '0;
            sqsum_next = '0;
        end
        else if (ctrl.accum)
        begin
            if (ctrl.add)
            begin
                count_next = count_next + NB'(1);
                sum_next   = sum_next + SB'(add_val);
                sqsum_next = sqsum_next + QB'(add_sq_reg);
            end
            if (ctrl.sub)
            begin
                count_next = count_next - NB'(1);
                sum_next   = sum_next - SB'(sub_val);
                sqsum_next = sqsum_next - QB'(sub_sq_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sqsum_reg <= sqsum_next;
        end
    end

    assign count = count_reg;
    assign sum   = sum_reg;
    assign sqsum = sqsum_reg;

endmodule

>>> hw/rtl/opp_test.sv
// ----------------------------------------------------------------------------
// opp_test
// Four-stage threshold test of the middle frame: local maximum against both
// neighbors, n*f - S > 0 and 16*(n*f - S)^2 > k^2*(n*Q - S^2).
// ----------------------------------------------------------------------------
module opp_test #(
    parameter int FLUX_BITS   = opp_pkg::FLUX_BITS_DEF,
    parameter int HALF_WINDOW = opp_pkg::HALF_WINDOW_DEF,
    localparam int NB = $clog2(2 * HALF_WINDOW + 2),
    localparam int SB = FLUX_BITS + NB,
    localparam int QB = 2 * FLUX_BITS + NB
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [FLUX_BITS-1:0]         f_mid,
    input  logic [FLUX_BITS-1:0]         f_newer,
    input  logic [FLUX_BITS-1:0]         f_older,
    input  logic [NB-1:0]                count,
    input  logic [SB-1:0]                sum,
    input  logic [QB-1:0]                sqsum,
    input  logic [opp_pkg::KK_BITS-1:0]  kk,
    output opp_pkg::test_res_t           res
);
    import opp_pkg::*;

    localparam int VB = 2 * SB;
    localparam int CW = VB + KK_BITS;

    logic [3:0]    stage_v_reg;
    logic [3:0]    stage_v_next;

    // stage 1
    logic          peak1_reg;
    logic [SB-1:0] nf1_reg;
    logic [SB-1:0] s1_reg;
    logic [VB-1:0] ss1_reg;
    logic [VB-1:0] nq1_reg;
    // stage 2
    logic          ok2_reg;
    logic [SB-1:0] a2_reg;
    logic [VB-1:0] var2_reg;
    // stage 3
    logic          ok3_reg;
    logic [VB-1:0] asq3_reg;
    logic [CW-1:0] rhs3_reg;
    // stage 4
    logic          hit4_reg;

    logic [CW-1:0] lhs3;

    assign lhs3 = CW'({asq3_reg, 4'b0000});

    always_ff @(posedge clk)
    begin
        peak1_reg <= (f_mid > f_newer) && (f_mid > f_older);
        nf1_reg   <= SB'(count) * SB'(f_mid);
        s1_reg    <= sum;
        ss1_reg   <= VB'(sum) * VB'(sum);
        nq1_reg   <= VB'(count) * VB'(sqsum);

        ok2_reg   <= peak1_reg && (nf1_reg > s1_reg);
        a2_reg    <= nf1_reg - s1_reg;
        var2_reg  <= nq1_reg - ss1_reg;

        ok3_reg   <= ok2_reg;
        asq3_reg  <= VB'(a2_reg) * VB'(a2_reg);
        rhs3_reg  <= CW'(var2_reg) * CW'(kk);

        hit4_reg  <= ok3_reg && (rhs3_reg < lhs3);
    end

    assign stage_v_next = {stage_v_reg[2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= '0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
        end
    end

    assign res.done = stage_v_reg[3];
    assign res.hit  = hit4_reg;

endmodule

>>> hw/rtl/onset_peak_picker.sv
// ----------------------------------------------------------------------------
// onset_peak_picker
// Adaptive-threshold onset picker over a stream of spectral-flux frames.
// ----------------------------------------------------------------------------
// One flux frame is taken per transfer, tlast marks the last frame of a
// sequence. A frame is reported as an onset when it is above both neighbors
// and above mean plus k/4 standard deviations of the frames within
// HALF_WINDOW on either side, the window clipped at the sequence ends; the
// first and last frames never qualify. Frames are held in a row of history
// cells; a frame is decided when the frame HALF_WINDOW later arrives. An
// ordinary frame passes accept, square, accumulate, the four-stage squared
// threshold compare and emit before the next frame is taken. A frame with
// tlast also flushes the pending frames, one history shift and one compare
// per frame, then sends an end marker (tuser high, tlast high, index and
// strength zero) and starts a new sequence. An onset or end marker waits in
// its state while the output register is full and m_axis_tready is low.
// Frame indices saturate at 2^INDEX_BITS-1.
// ----------------------------------------------------------------------------
module onset_peak_picker #(
    parameter int HALF_WINDOW = opp_pkg::HALF_WINDOW_DEF,
    parameter int FLUX_BITS   = opp_pkg::FLUX_BITS_DEF,
    parameter int INDEX_BITS  = opp_pkg::INDEX_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // input frames
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic [((FLUX_BITS+7)/8)*8-1:0]              s_axis_tdata,   // flux_value
    input  logic                                        s_axis_tlast,   // end_of_sequence
    // results
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [((INDEX_BITS+FLUX_BITS+7)/8)*8-1:0]   m_axis_tdata,   // frame_index, onset_strength
    output logic                                        m_axis_tuser,   // end_marker
    output logic                                        m_axis_tlast,   // run_last
    // configuration
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [opp_pkg::ADDR_BITS-1:0]               paddr,
    input  logic [opp_pkg::APB_DATA_BITS-1:0]           pwdata,
    output logic [opp_pkg::APB_DATA_BITS-1:0]           prdata,
    output logic                                        pready
);
    import opp_pkg::*;

    localparam int DEPTH = 2 * HALF_WINDOW + 2;
    localparam int NB    = $clog2(2 * HALF_WINDOW + 2);
    localparam int SB    = FLUX_BITS + NB;
    localparam int QB    = 2 * FLUX_BITS + NB;
    localparam int PB    = $clog2(HALF_WINDOW + 1);
    localparam int RB    = INDEX_BITS + 1;
    localparam int OW    = ((INDEX_BITS + FLUX_BITS + 7) / 8) * 8;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQUARE = 6'b000010,
        ST_ACCUM  = 6'b000100,
        ST_TEST   = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_MARK   = 6'b100000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;

    logic [SCALE_BITS-1:0]   scale_reg;
    logic [KK_BITS-1:0]      kk_reg;
    logic                    cfg_write;

    logic [INDEX_BITS-1:0]   frames_reg;
    logic [INDEX_BITS-1:0]   frames_next;
    logic [INDEX_BITS-1:0]   before_reg;
    logic                    eos_reg;
    logic                    flushing_reg;
    logic                    flushing_next;
    logic [PB-1:0]           pos_reg;
    logic [PB-1:0]           pos_next;
    logic                    test_go_reg;
    logic                    hit_reg;
    logic                    hit_next;

    logic                    out_valid_reg;
    logic [INDEX_BITS-1:0]   out_index_reg;
    logic [FLUX_BITS-1:0]    out_strength_reg;
    logic                    out_end_reg;
    logic                    out_last_reg;
    logic                    out_free;
    logic                    load_onset;
    logic                    load_marker;

    logic                    accept;
    logic                    chain_shift;
    logic                    chain_clear;
    logic [FLUX_BITS-1:0]    chain_in;
    logic [FLUX_BITS-1:0]    hist [DEPTH];

    win_ctrl_t               win_ctrl;
    logic [NB-1:0]           win_count;
    logic [SB-1:0]           win_sum;
    logic [QB-1:0]           win_sqsum;
    test_res_t               test_res;

    logic                    sat;
    logic                    tested;
    logic                    rem_normal;
    logic                    rem_flush;
    logic [INDEX_BITS-1:0]   onset_index;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD_SCALE);
    assign prdata    = (paddr[2] == REG_THRESHOLD_SCALE) ? APB_DATA_BITS'(scale_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            kk_reg    <= KK_BITS'(SCALE_RESET) * KK_BITS'(SCALE_RESET);
        end
        else if (cfg_write)
        begin
            scale_reg <= pwdata[SCALE_BITS-1:0];
            kk_reg    <= KK_BITS'(pwdata[SCALE_BITS-1:0]) * KK_BITS'(pwdata[SCALE_BITS-1:0]);
        end
    end

    // history line
    assign accept      = s_axis_tvalid && s_axis_tready;
    assign chain_shift = accept || ((state_reg == ST_ACCUM) && flushing_reg);
    assign chain_in    = accept ? s_axis_tdata[FLUX_BITS-1:0] : '0;

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        opp_cell #(
            .FLUX_BITS (FLUX_BITS)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (chain_shift),
            .clear (chain_clear),
            .din   ((j == 0) ? chain_in : hist[(j == 0) ? 0 : j - 1]),
            .dout  (hist[j])
        );
    end

    // window statistics
    assign rem_normal = RB'(before_reg) >= RB'(2 * HALF_WINDOW + 1);
    assign rem_flush  = RB'(before_reg) >= (RB'(pos_reg) + RB'(HALF_WINDOW));

    always_comb
    begin
        win_ctrl        = '0;
        win_ctrl.square = (state_reg == ST_SQUARE);
        win_ctrl.accum  = (state_reg == ST_ACCUM);
        win_ctrl.add    = !flushing_reg;
        win_ctrl.sub    = flushing_reg ? rem_flush : rem_normal;
        win_ctrl.clear  = chain_clear;
    end

    opp_window #(
        .FLUX_BITS   (FLUX_BITS),
        .HALF_WINDOW (HALF_WINDOW)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (win_ctrl),
        .add_val (hist[0]),
        .sub_val (flushing_reg ? hist[2*HALF_WINDOW] : hist[2*HALF_WINDOW+1]),
        .count   (win_count),
        .sum     (win_sum),
        .sqsum   (win_sqsum)
    );

    // threshold test of the middle cell
    opp_test #(
        .FLUX_BITS   (FLUX_BITS),
        .HALF_WINDOW (HALF_WINDOW)
    ) u_test (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (test_go_reg),
        .f_mid   (hist[HALF_WINDOW]),
        .f_newer (hist[HALF_WINDOW-1]),
        .f_older (hist[HALF_WINDOW+1]),
        .count   (win_count),
        .sum     (win_sum),
        .sqsum   (win_sqsum),
        .kk      (kk_reg),
        .res     (test_res)
    );

    // frame at the middle cell is a candidate unless it is first, last or absent
    assign tested      = (RB'(before_reg) > RB'(pos_reg)) && (pos_reg != '0);
    assign sat         = (before_reg == {INDEX_BITS{1'b1}});
    assign onset_index = sat ? {INDEX_BITS{1'b1}} : (before_reg - INDEX_BITS'(pos_reg));

    assign out_free    = !out_valid_reg || m_axis_tready;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        flushing_next = flushing_reg;
        pos_next      = pos_reg;
        hit_next      = hit_reg;
        frames_next   = frames_reg;
        load_onset    = 1'b0;
        load_marker   = 1'b0;
        chain_clear   = 1'b0;
        s_axis_tready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_SQUARE;
                    flushing_next = 1'b0;
                    pos_next      = PB'(HALF_WINDOW);
                    if (frames_reg != {INDEX_BITS{1'b1}})
                    begin
                        frames_next = frames_reg + INDEX_BITS'(1);
                    end
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = ST_TEST;
                if (flushing_reg)
                begin
                    pos_next = pos_reg - PB'(1);
                end
            end
            ST_TEST:
            begin
                if (test_res.done)
                begin
                    hit_next   = test_res.hit && tested;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!hit_reg || out_free)
                begin
                    load_onset = hit_reg;
                    if (!eos_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pos_reg == '0)
                    begin
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        flushing_next = 1'b1;
                        state_next    = ST_SQUARE;
                    end
                end
            end
            ST_MARK:
            begin
                if (out_free)
                begin
                    load_marker   = 1'b1;
                    chain_clear   = 1'b1;
                    frames_next   = '0;
                    flushing_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            flushing_reg <= 1'b0;
            pos_reg      <= '0;
            hit_reg      <= 1'b0;
            frames_reg   <= '0;
            before_reg   <= '0;
            eos_reg      <= 1'b0;
            test_go_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            flushing_reg <= flushing_next;
            pos_reg      <= pos_next;
            hit_reg      <= hit_next;
            frames_reg   <= frames_next;
            test_go_reg  <= (state_reg == ST_ACCUM);
            if (accept)
            begin
                before_reg <= frames_reg;
                eos_reg    <= s_axis_tlast;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_onset || load_marker)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_onset)
        begin
            out_index_reg    <= onset_index;
            out_strength_reg <= hist[HALF_WINDOW];
            out_end_reg      <= 1'b0;
            out_last_reg     <= !eos_reg;
        end
        else if (load_marker)
        begin
            out_index_reg    <= '0;
            out_strength_reg <= '0;
            out_end_reg      <= 1'b1;
            out_last_reg     <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'({out_strength_reg, out_index_reg});
    assign m_axis_tuser  = out_end_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> hw/rtl/opp_checker.sv
// ----------------------------------------------------------------------------
// opp_checker
// Port-level checks of the onset peak picker, bound to the top level.
// ----------------------------------------------------------------------------
module opp_checker #(
    parameter int FLUX_BITS  = opp_pkg::FLUX_BITS_DEF,
    parameter int INDEX_BITS = opp_pkg::INDEX_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    input  logic                                        s_axis_tready,
    input  logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    input  logic [((INDEX_BITS+FLUX_BITS+7)/8)*8-1:0]   m_axis_tdata,
    input  logic                                        m_axis_tuser,
    input  logic                                        m_axis_tlast,
    input  logic                                        pready
);

    // a result held back keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
    else $error("stalled result changed");

    // end marker carries no onset and closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0) && m_axis_tlast)
    else $error("end marker with payload or without tlast");

    // one frame at a time: no input transfer right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a frame is in work");

    // configuration port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
    else $error("pready low");

endmodule

bind onset_peak_picker opp_checker #(
    .FLUX_BITS  (FLUX_BITS),
    .INDEX_BITS (INDEX_BITS)
) u_opp_checker (.*);
